/* hdl/bpp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers of the 1D Boris particle pusher.
package bpp_pkg;

  localparam int MAX_CELLS  = 1024;
  localparam int CELL_W     = $clog2(MAX_CELLS);
  localparam int NUM_COMP   = 6;
  localparam int DIV_STAGES = 32;
  localparam int QDEPTH     = 4;
  localparam int IN_DW      = 272;
  localparam int OUT_DW     = 192;

  localparam logic signed [31:0] ONE = 32'sd65536;
  localparam logic signed [31:0] TWO = 32'sd131072;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_VEL  = 2'd1,
    CMD_POS  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_QM    = 2'd0,
    REG_DT    = 2'd1,
    REG_ICW   = 2'd2,
    REG_CELLS = 2'd3
  } reg_t;

  typedef struct packed {
    logic signed [31:0] qm;
    logic [30:0]        dt;
    logic [30:0]        icw;
    logic [CELL_W:0]    ncell;
  } cfg_t;

  typedef struct packed {
    logic              ld;
    logic              is_pos;
    logic              last;
    logic [CELL_W-1:0] cidx;
    logic [2:0]        comp;
    logic [31:0]       fval;
    logic [2:0][31:0]  p;
    logic [2:0][31:0]  v;
    logic [31:0]       g;
  } itm_t;

  typedef struct packed {
    logic              vld;
    logic              ld;
    logic              is_pos;
    logic              last;
    logic              flag;
    logic [CELL_W-1:0] c1;
    logic [CELL_W-1:0] c2;
    logic [2:0]        comp;
    logic [15:0]       frac;
    logic [31:0]       g;
    logic [31:0]       xo;
    logic [2:0][31:0]  p;
    logic [2:0][31:0]  v;
    logic [2:0][31:0]  t;
    logic [2:0][31:0]  e;
    logic [2:0][31:0]  vm;
    logic [2:0][31:0]  w;
    logic [2:0][31:0]  s;
    logic [5:0][31:0]  f;
    logic [11:0][31:0] mp;
    logic [31:0]       den;
  } bk_t;

  typedef struct packed {
    logic [CELL_W-1:0] cidx;
    logic              flag;
  } loc_t;

  function automatic logic signed [31:0] sat66(input logic signed [65:0] x);
    if (!x[65] && (|x[64:31])) return 32'sh7fffffff;
    if (x[65] && !(&x[64:31])) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Q16.16 product, floored, saturated
  function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] pr;
    logic signed [63:0] q;
    pr = a * b;
    q  = pr >>> 16;
    return sat66({{2{q[63]}}, q});
  endfunction

  // saturated a + b - c
  function automatic logic signed [31:0] addsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic signed [31:0] c);
    logic [65:0] s;
    s = {{34{a[31]}}, a} + {{34{b[31]}}, b} - {{34{c[31]}}, c};
    return sat66(s);
  endfunction

  function automatic logic [CELL_W:0] cells_used(input logic [10:0] raw);
    if (raw == 11'd0) return (CELL_W+1)'(1);
    if (int'(raw) > MAX_CELLS) return (CELL_W+1)'(MAX_CELLS);
    return (CELL_W+1)'(raw);
  endfunction

  // cell from the scaled position, clamped to the grid
  function automatic loc_t locate(input logic [31:0] xo, input logic [CELL_W:0] n);
    loc_t r;
    if (xo[31]) begin
      r.cidx = '0;
      r.flag = 1'b1;
    end else if (32'(xo[30:16]) >= 32'(n)) begin
      r.cidx = CELL_W'(n - 1'b1);
      r.flag = 1'b1;
    end else begin
      r.cidx = CELL_W'(xo[30:16]);
      r.flag = 1'b0;
    end
    return r;
  endfunction

endpackage

/* hdl/boris_particle_pusher_1d.sv */
`timescale 1ns / 1ps
// Top level of the 1D Boris particle pusher with linearly interpolated fields.
//
//  channel  | direction | beat accepted on
//  ---------+-----------+---------------------------------------------
//  in_      | slave     | in_tvalid & in_tready
//  out_     | master    | out_tvalid & out_tready
//  cfg_     | APB slave | cfg_psel & cfg_penable & cfg_pwrite (write)
//
//  One item per cycle in steady state while the output is not stalled; each kept
//  item passes through the input queue and then the back pipeline, most of
//  which is the two 32-stage dividers (gamma divide, then the rotation scale divide).
//  Loads write the field store at the memory stage, in order with pushes.
//  rst_n is synchronous; the field store is not cleared.
//  A stalled output freezes the back pipeline; the queue keeps taking beats until full.
module boris_particle_pusher_1d (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // cell_index, component, field_value, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
  // lorentz_factor, zero fill
  input  logic [bpp_pkg::IN_DW-1:0]   in_tdata,
  // command
  input  logic [1:0]                  in_tuser,
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
  output logic [bpp_pkg::OUT_DW-1:0]  out_tdata,
  // out_of_grid
  output logic                        out_tuser,
  output logic                        out_tlast,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [3:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import bpp_pkg::*;

  logic signed [31:0] qm_r;
  logic [30:0] dt_r, icw_r;
  logic [10:0] cells_r;
  reg_t ridx;
  logic wr;
  cfg_t cfg;
  logic itm_vld, pop;
  itm_t itm;
  bk_t res;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx       = reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qm_r    <= '0;
      dt_r    <= 31'd65536;
      icw_r   <= 31'd65536;
      cells_r <= 11'd1024;
    end else if (wr) begin
      case (ridx)
        REG_QM:    qm_r    <= cfg_pwdata;
        REG_DT:    dt_r    <= cfg_pwdata[30:0];
        REG_ICW:   icw_r   <= cfg_pwdata[30:0];
        REG_CELLS: cells_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_QM:    cfg_prdata = qm_r;
      REG_DT:    cfg_prdata = {1'b0, dt_r};
      REG_ICW:   cfg_prdata = {1'b0, icw_r};
      REG_CELLS: cfg_prdata = {21'b0, cells_r};
      default:   cfg_prdata = '0;
    endcase
  end

  assign cfg.qm    = qm_r;
  assign cfg.dt    = dt_r;
  assign cfg.icw   = icw_r;
  assign cfg.ncell = cells_used(cells_r);

  bpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .pop       (pop),
    .itm_vld   (itm_vld),
    .itm       (itm)
  );

  bpp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .itm_vld    (itm_vld),
    .itm        (itm),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res        (res)
  );

  assign out_tdata = {res.v[2], res.v[1], res.v[0], res.p[2], res.p[1], res.p[0]};
  assign out_tuser = res.flag;
  assign out_tlast = res.last;
endmodule

/* hdl/bpp_front.sv */
`timescale 1ns / 1ps
// Front part: accepts beats, drops dead commands, queues work for the back part.
module bpp_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [bpp_pkg::IN_DW-1:0]  in_tdata,
  input  logic [1:0]                 in_tuser,
  input  logic                       in_tlast,
  input  logic                       pop,
  output logic                       itm_vld,
  output bpp_pkg::itm_t              itm
);
  import bpp_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  itm_t          q_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  cmd_t          cmd;
  logic          keep, push;
  logic [30:0]   gam;
  itm_t          cur;

  always_comb begin
    cmd = cmd_t'(in_tuser);
    case (cmd)
      CMD_LOAD: keep = in_tdata[12:10] < 3'(NUM_COMP);
      CMD_VEL:  keep = 1'b1;
      CMD_POS:  keep = 1'b1;
      default:  keep = 1'b0;
    endcase
    gam         = in_tdata[267:237];
    cur.ld      = cmd == CMD_LOAD;
    cur.is_pos  = cmd == CMD_POS;
    cur.last    = in_tlast;
    cur.cidx    = CELL_W'(in_tdata[9:0]);
    cur.comp    = in_tdata[12:10];
    cur.fval    = in_tdata[44:13];
    cur.p[0]    = in_tdata[76:45];
    cur.p[1]    = in_tdata[108:77];
    cur.p[2]    = in_tdata[140:109];
    cur.v[0]    = in_tdata[172:141];
    cur.v[1]    = in_tdata[204:173];
    cur.v[2]    = in_tdata[236:205];
    // gamma below one counts as one
    cur.g       = (gam < 31'd65536) ? 32'd65536 : {1'b0, gam};
  end

  assign in_tready = cnt_r != (PW+1)'(QDEPTH);
  assign push      = in_tvalid && in_tready && keep;
  assign itm_vld   = cnt_r != '0;
  assign itm       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= cur;
  end

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("queue popped while empty");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count lost a push");
  a_cnt_dn: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> cnt_r == $past(cnt_r) - 1'b1) else $error("queue count lost a pop");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[PW-1:0] == PW'(wp_r - rp_r)) else $error("queue pointers and count disagree");
  a_load_comp: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!cur.ld || cur.comp < 3'(NUM_COMP))) else $error("bad load queued");
`endif
endmodule

/* hdl/bpp_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, payload alongside.
module bpp_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic signed [31:0] num,
  input  logic [31:0]        den,
  input  bpp_pkg::bk_t       pay_i,
  output logic [31:0]        quo,
  output bpp_pkg::bk_t       pay_o
);
  import bpp_pkg::*;

  logic [31:0] rem_r [DIV_STAGES];
  logic [31:0] sh_r  [DIV_STAGES];
  logic [31:0] d_r   [DIV_STAGES];
  logic        neg_r [DIV_STAGES];
  bk_t         pay_r [DIV_STAGES];

  logic [31:0] rem_p [DIV_STAGES];
  logic [31:0] sh_p  [DIV_STAGES];
  logic [31:0] d_p   [DIV_STAGES];
  logic        neg_p [DIV_STAGES];
  bk_t         pay_p [DIV_STAGES];
  logic [31:0] rem_n [DIV_STAGES];
  logic [31:0] sh_n  [DIV_STAGES];
  logic [31:0] mag;
  logic [32:0] r2    [DIV_STAGES];
  logic [32:0] df    [DIV_STAGES];
  logic        ge    [DIV_STAGES];

  // dividend is |num| << 16; the divisor is at least one, so the top 16 quotient bits are 0
  assign mag = num[31] ? 32'(-num) : num;

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        rem_p[k] = {16'b0, mag[31:16]};
        sh_p[k]  = {mag[15:0], 16'b0};
        d_p[k]   = den;
        neg_p[k] = num[31];
        pay_p[k] = pay_i;
      end else begin
        rem_p[k] = rem_r[k-1];
        sh_p[k]  = sh_r[k-1];
        d_p[k]   = d_r[k-1];
        neg_p[k] = neg_r[k-1];
        pay_p[k] = pay_r[k-1];
      end
      r2[k]    = {rem_p[k], sh_p[k][31]};
      df[k]    = r2[k] - {1'b0, d_p[k]};
      ge[k]    = r2[k] >= {1'b0, d_p[k]};
      rem_n[k] = ge[k] ? df[k][31:0] : r2[k][31:0];
      sh_n[k]  = {sh_p[k][30:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) pay_r[k].vld <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k < DIV_STAGES; k++) pay_r[k] <= pay_p[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        rem_r[k] <= rem_n[k];
        sh_r[k]  <= sh_n[k];
        d_r[k]   <= d_p[k];
        neg_r[k] <= neg_p[k];
      end
    end
  end

  assign quo   = neg_r[DIV_STAGES-1] ? 32'(-sh_r[DIV_STAGES-1]) : sh_r[DIV_STAGES-1];
  assign pay_o = pay_r[DIV_STAGES-1];
endmodule

/* hdl/bpp_fstore.sv */
`timescale 1ns / 1ps
// Field store: one memory per component, one write port and two read ports each.
module bpp_fstore (
  input  logic                                  clk,
  input  logic                                  adv,
  input  logic                                  wr_en,
  input  logic [2:0]                            wr_comp,
  input  logic [bpp_pkg::CELL_W-1:0]            wr_cell,
  input  logic [31:0]                           wr_data,
  input  logic [bpp_pkg::CELL_W-1:0]            rd_a,
  input  logic [bpp_pkg::CELL_W-1:0]            rd_b,
  output logic [bpp_pkg::NUM_COMP-1:0][31:0]    rd1,
  output logic [bpp_pkg::NUM_COMP-1:0][31:0]    rd2
);
  import bpp_pkg::*;

  for (genvar k = 0; k < NUM_COMP; k++) begin : g_comp
    logic [31:0] mem [MAX_CELLS];
    logic [31:0] ra_r, rb_r;

    always_ff @(posedge clk) begin
      if (adv && wr_en && wr_comp == 3'(k)) mem[wr_cell] <= wr_data;
      if (adv) begin
        ra_r <= mem[rd_a];
        rb_r <= mem[rd_b];
      end
    end

    assign rd1[k] = ra_r;
    assign rd2[k] = rb_r;
  end
endmodule

/* hdl/bpp_back.sv */
`timescale 1ns / 1ps
// Back part: field interpolation, Boris rotation and position advance pipeline.
module bpp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  bpp_pkg::cfg_t cfg,
  input  logic          itm_vld,
  input  bpp_pkg::itm_t itm,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output bpp_pkg::bk_t  res
);
  import bpp_pkg::*;

  bk_t sa_r, sb_r, sc_r, sd_r, se_r, sf_r, sg_r, sh_r, si_r, sj_r, sk_r, sl_r, sm_r;
  bk_t sa_nxt, sb_nxt, sc_nxt, sd_nxt, se_nxt, sf_nxt, sg_nxt, sh_nxt, si_nxt;
  bk_t sj_nxt, sk_nxt, sl_nxt, sm_nxt;
  bk_t d1_o, d2_o;
  logic [31:0] q1, q2;
  logic [NUM_COMP-1:0][31:0] rd1, rd2;
  logic adv;
  loc_t loc_b, loc_i;
  logic [CELL_W:0] nx;
  logic [31:0] omf, fr;
  logic [65:0] dsum;
  logic signed [31:0] ds;
  logic [31:0] icw32;

  // hold the whole pipe while a result waits
  assign adv        = !sm_r.vld || out_tready;
  assign pop        = adv && itm_vld;
  assign out_tvalid = sm_r.vld;
  assign res        = sm_r;
  assign icw32      = {1'b0, cfg.icw};

  always_comb begin
    sa_nxt        = '0;
    sa_nxt.vld    = itm_vld;
    sa_nxt.ld     = itm.ld;
    sa_nxt.is_pos = itm.is_pos;
    sa_nxt.last   = itm.last;
    sa_nxt.c1     = itm.cidx;
    sa_nxt.comp   = itm.comp;
    sa_nxt.p      = itm.p;
    sa_nxt.v      = itm.v;
    sa_nxt.g      = itm.g;
    sa_nxt.xo     = itm.ld ? itm.fval : fmul(itm.p[0], icw32);
  end

  always_comb begin
    sb_nxt = sa_r;
    loc_b  = locate(sa_r.xo, cfg.ncell);
    if (!sa_r.ld) begin
      sb_nxt.c1   = loc_b.cidx;
      sb_nxt.flag = loc_b.flag;
    end
    sb_nxt.frac = sa_r.xo[15:0];
    nx = {1'b0, sb_nxt.c1} + 1'b1;
    sb_nxt.c2 = (nx == cfg.ncell) ? '0 : nx[CELL_W-1:0];
  end

  bpp_fstore u_fstore (
    .clk     (clk),
    .adv     (adv),
    .wr_en   (sb_r.vld && sb_r.ld),
    .wr_comp (sb_r.comp),
    .wr_cell (sb_r.c1),
    .wr_data (sb_r.xo),
    .rd_a    (sb_r.c1),
    .rd_b    (sb_r.c2),
    .rd1     (rd1),
    .rd2     (rd2)
  );

  always_comb begin
    sc_nxt     = sb_r;
    // drop loads once written
    sc_nxt.vld = sb_r.vld && !sb_r.ld;
  end

  always_comb begin
    sd_nxt = sc_r;
    omf    = {15'b0, 17'd65536 - {1'b0, sc_r.frac}};
    fr     = {16'b0, sc_r.frac};
    for (int k = 0; k < NUM_COMP; k++) begin
      sd_nxt.mp[2*k]   = fmul(rd1[k], omf);
      sd_nxt.mp[2*k+1] = fmul(rd2[k], fr);
    end
  end

  always_comb begin
    se_nxt = sd_r;
    for (int k = 0; k < NUM_COMP; k++)
      se_nxt.f[k] = addsub(sd_r.mp[2*k], sd_r.mp[2*k+1], '0);
  end

  // q/m over gamma, or dt over gamma
  bpp_div u_div1 (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .num   (se_r.is_pos ? {1'b0, cfg.dt} : cfg.qm),
    .den   (se_r.g),
    .pay_i (se_r),
    .quo   (q1),
    .pay_o (d1_o)
  );

  always_comb begin
    sf_nxt = d1_o;
    for (int k = 0; k < 3; k++) begin
      if (d1_o.is_pos) begin
        sf_nxt.mp[k] = fmul(q1, d1_o.v[k]);
      end else begin
        sf_nxt.t[k] = fmul(q1, d1_o.f[k]);
        sf_nxt.e[k] = fmul(cfg.qm, d1_o.f[3+k]);
      end
    end
  end

  always_comb begin
    sg_nxt = sf_r;
    for (int k = 0; k < 3; k++) begin
      if (sf_r.is_pos) begin
        sg_nxt.p[k] = addsub(sf_r.p[k], sf_r.mp[k], '0);
      end else begin
        sg_nxt.mp[k] = fmul(sf_r.t[k], sf_r.t[k]);
        sg_nxt.vm[k] = addsub(sf_r.v[k], sf_r.e[k], '0);
      end
    end
  end

  always_comb begin
    sh_nxt = sg_r;
    dsum = 66'(ONE) + {{34{sg_r.mp[0][31]}}, sg_r.mp[0]}
         + {{34{sg_r.mp[1][31]}}, sg_r.mp[1]} + {{34{sg_r.mp[2][31]}}, sg_r.mp[2]};
    ds = sat66(dsum);
    if (sg_r.is_pos) begin
      sh_nxt.xo = fmul(sg_r.p[0], icw32);
    end else begin
      sh_nxt.den   = (ds < ONE) ? ONE : ds;
      sh_nxt.mp[0] = fmul(sg_r.vm[1], sg_r.t[2]);
      sh_nxt.mp[1] = fmul(sg_r.vm[2], sg_r.t[1]);
      sh_nxt.mp[2] = fmul(sg_r.vm[2], sg_r.t[0]);
      sh_nxt.mp[3] = fmul(sg_r.vm[0], sg_r.t[2]);
      sh_nxt.mp[4] = fmul(sg_r.vm[0], sg_r.t[1]);
      sh_nxt.mp[5] = fmul(sg_r.vm[1], sg_r.t[0]);
    end
  end

  always_comb begin
    si_nxt = sh_r;
    loc_i  = locate(sh_r.xo, cfg.ncell);
    if (sh_r.is_pos) begin
      si_nxt.flag = loc_i.flag;
    end else begin
      for (int k = 0; k < 3; k++)
        si_nxt.w[k] = addsub(sh_r.vm[k], sh_r.mp[2*k], sh_r.mp[2*k+1]);
    end
  end

  // 2 / (1 + |t|^2)
  bpp_div u_div2 (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .num   (TWO),
    .den   (si_r.den),
    .pay_i (si_r),
    .quo   (q2),
    .pay_o (d2_o)
  );

  always_comb begin
    sj_nxt = d2_o;
    for (int k = 0; k < 3; k++)
      sj_nxt.s[k] = fmul(q2, d2_o.t[k]);
  end

  always_comb begin
    sk_nxt       = sj_r;
    sk_nxt.mp[0] = fmul(sj_r.w[1], sj_r.s[2]);
    sk_nxt.mp[1] = fmul(sj_r.w[2], sj_r.s[1]);
    sk_nxt.mp[2] = fmul(sj_r.w[2], sj_r.s[0]);
    sk_nxt.mp[3] = fmul(sj_r.w[0], sj_r.s[2]);
    sk_nxt.mp[4] = fmul(sj_r.w[0], sj_r.s[1]);
    sk_nxt.mp[5] = fmul(sj_r.w[1], sj_r.s[0]);
  end

  always_comb begin
    sl_nxt = sk_r;
    for (int k = 0; k < 3; k++)
      sl_nxt.vm[k] = addsub(sk_r.vm[k], sk_r.mp[2*k], sk_r.mp[2*k+1]);
  end

  always_comb begin
    sm_nxt = sl_r;
    if (!sl_r.is_pos) begin
      for (int k = 0; k < 3; k++)
        sm_nxt.v[k] = addsub(sl_r.vm[k], sl_r.e[k], '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r.vld <= 1'b0;
      sb_r.vld <= 1'b0;
      sc_r.vld <= 1'b0;
      sd_r.vld <= 1'b0;
      se_r.vld <= 1'b0;
      sf_r.vld <= 1'b0;
      sg_r.vld <= 1'b0;
      sh_r.vld <= 1'b0;
      si_r.vld <= 1'b0;
      sj_r.vld <= 1'b0;
      sk_r.vld <= 1'b0;
      sl_r.vld <= 1'b0;
      sm_r.vld <= 1'b0;
    end else if (adv) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
      sc_r <= sc_nxt;
      sd_r <= sd_nxt;
      se_r <= se_nxt;
      sf_r <= sf_nxt;
      sg_r <= sg_nxt;
      sh_r <= sh_nxt;
      si_r <= si_nxt;
      sj_r <= sj_nxt;
      sk_r <= sk_nxt;
      sl_r <= sl_nxt;
      sm_r <= sm_nxt;
    end
  end
endmodule
